// ===== design/rlcs_pkg.sv =====
package rlcs_pkg;

   // fixed geometry of one led word
   localparam int BITS_PER_LED = 24;
   localparam int COLOUR_W     = 24;
   localparam int BIT_W        = 5;
   localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(BITS_PER_LED - 1);

   // request command codes
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   // classified operation codes
   localparam logic [1:0] OP_NONE  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_START = 2'd2;
   localparam logic [1:0] OP_TICK  = 2'd3;

   // csr register indexes
   localparam logic [1:0] CSR_ONE_HIGH  = 2'd0;
   localparam logic [1:0] CSR_ZERO_HIGH = 2'd1;
   localparam logic [1:0] CSR_PERIOD    = 2'd2;
   localparam logic [1:0] CSR_RST_SLOTS = 2'd3;

   // csr reset values
   localparam logic [7:0] ONE_HIGH_RST  = 8'd53;
   localparam logic [7:0] ZERO_HIGH_RST = 8'd21;
   localparam logic [7:0] PERIOD_RST    = 8'd90;
   localparam logic [7:0] RST_SLOTS_RST = 8'd45;

   typedef struct packed {
      logic [1:0]          kind;
      logic [4:0]          idx;
      logic [COLOUR_W-1:0] colour;
   } op_type;

   // reset slot count kept as whole led words plus leftover bits
   typedef struct packed {
      logic [7:0]       one_high_ticks;
      logic [7:0]       zero_high_ticks;
      logic [7:0]       bit_period_ticks;
      logic [3:0]       rst_words;
      logic [BIT_W-1:0] rst_bits;
   } cfg_type;

   // whole led words in a slot count, (x * 171) >> 12 is x / 24 for any 8-bit x
   function automatic logic [3:0] slot_words(logic [7:0] slots);
      logic [15:0] prod;
      prod = {8'b0, slots} * 16'd171;
      return prod[15:12];
   endfunction

   // slots left over after the whole led words
   function automatic logic [BIT_W-1:0] slot_bits(logic [7:0] slots);
      logic [7:0] whole;
      whole = {4'b0, slot_words(slots)};
      whole = slots - ((whole << 4) + (whole << 3));
      return whole[BIT_W-1:0];
   endfunction

endpackage

// ===== design/rlcs_front.sv =====
module rlcs_front #(
   parameter int LED_TOTAL = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_cmd,
   input  logic [4:0]           req_pixel_index,
   input  logic [7:0]           req_red,
   input  logic [7:0]           req_green,
   input  logic [7:0]           req_blue,
   output logic                 op_valid,
   output rlcs_pkg::op_type     op,
   input  logic                 op_pop
);

   localparam logic [10:0] LED_LIMIT = 11'(LED_TOTAL);

   rlcs_pkg::op_type q_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   rlcs_pkg::op_type new_op;
   logic             push;

   // classify the incoming command
   always_comb begin
      new_op.idx    = req_pixel_index;
      new_op.colour = {req_green, req_red, req_blue};
      case (req_cmd)
         rlcs_pkg::CMD_WRITE: begin
            new_op.kind = ({6'b0, req_pixel_index} < LED_LIMIT) ? rlcs_pkg::OP_WRITE
                                                                : rlcs_pkg::OP_NONE;
         end
         rlcs_pkg::CMD_START: new_op.kind = rlcs_pkg::OP_START;
         rlcs_pkg::CMD_TICK:  new_op.kind = rlcs_pkg::OP_TICK;
         default:             new_op.kind = rlcs_pkg::OP_NONE;
      endcase
   end

   // two-entry queue toward the back end
   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign op_valid  = (cnt_ff != 2'd0);
   assign op        = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = op_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(op_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_op;
      end
   end

endmodule

// ===== design/rlcs_back.sv =====
module rlcs_back #(
   parameter int LED_TOTAL = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  rlcs_pkg::cfg_type cfg,
   input  logic              op_valid,
   input  rlcs_pkg::op_type  op,
   output logic              op_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_line_level,
   output logic              rsp_busy_res,
   output logic              rsp_frame_done
);

   // only indexes below 32 can ever be written, the rest stay black
   localparam int STORE_DEPTH = (LED_TOTAL < 32) ? LED_TOTAL : 32;
   localparam int SIDX_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   // frame slot position counted as whole led words plus a bit in the word
   localparam int WORD_W      = $clog2(LED_TOTAL + 16);
   localparam logic [WORD_W-1:0] LED_LIMIT   = WORD_W'(LED_TOTAL);
   localparam logic [WORD_W-1:0] STORE_LIMIT = WORD_W'(STORE_DEPTH);

   logic [rlcs_pkg::COLOUR_W-1:0] store_ff [STORE_DEPTH];
   logic [rlcs_pkg::COLOUR_W-1:0] store_in [STORE_DEPTH];
   logic                          sending_ff, sending_in;
   logic [WORD_W-1:0]             word_ff, word_in;
   logic [rlcs_pkg::BIT_W-1:0]    bit_ff, bit_in;
   logic [7:0]                    tick_ff, tick_in;
   logic                          done_in;
   logic [7:0]                    tick_plus;
   logic [WORD_W-1:0]             lead_word;
   logic [WORD_W-1:0]             end_word;
   logic                          in_lead;
   logic                          borrow;
   logic [WORD_W-1:0]             led;
   logic [rlcs_pkg::BIT_W-1:0]    data_bit;
   logic [rlcs_pkg::COLOUR_W-1:0] colour;
   logic                          cur_bit;
   logic [7:0]                    high_ticks;
   logic                          level_in;
   logic                          rsp_valid_ff;
   logic                          level_ff, busy_ff, done_ff;

   // take an op whenever the output register is free or draining
   assign op_pop = op_valid && (!rsp_valid_ff || rsp_ready);

   // lead-in length and frame length in the same word/bit form
   assign lead_word = {{(WORD_W-4){1'b0}}, cfg.rst_words};
   assign end_word  = lead_word + LED_LIMIT;

   // state update for one op
   always_comb begin
      store_in   = store_ff;
      sending_in = sending_ff;
      word_in    = word_ff;
      bit_in     = bit_ff;
      tick_in    = tick_ff;
      done_in    = 1'b0;
      tick_plus  = tick_ff + 8'd1;
      if (op_pop) begin
         case (op.kind)
            rlcs_pkg::OP_WRITE: begin
               store_in[op.idx[SIDX_W-1:0]] = op.colour;
            end
            rlcs_pkg::OP_START: begin
               if (!sending_ff) begin
                  sending_in = 1'b1;
                  word_in    = '0;
                  bit_in     = '0;
                  tick_in    = 8'd0;
               end
            end
            rlcs_pkg::OP_TICK: begin
               if (sending_ff) begin
                  if (tick_plus >= cfg.bit_period_ticks) begin
                     tick_in = 8'd0;
                     if (bit_ff == rlcs_pkg::BIT_LAST) begin
                        bit_in  = '0;
                        word_in = word_ff + WORD_W'(1);
                     end else begin
                        bit_in = bit_ff + rlcs_pkg::BIT_W'(1);
                     end
                     // frame ends once the slot count reaches lead-in plus data
                     if ((word_in > end_word) ||
                         ((word_in == end_word) && (bit_in >= cfg.rst_bits))) begin
                        sending_in = 1'b0;
                        word_in    = '0;
                        bit_in     = '0;
                        done_in    = 1'b1;
                     end
                  end else begin
                     tick_in = tick_plus;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // line level after this op, store read with the write folded in
   always_comb begin
      in_lead    = (word_in < lead_word) ||
                   ((word_in == lead_word) && (bit_in < cfg.rst_bits));
      borrow     = (bit_in < cfg.rst_bits);
      led        = word_in - lead_word - WORD_W'(borrow);
      data_bit   = borrow ?
                   (bit_in + rlcs_pkg::BIT_W'(rlcs_pkg::BITS_PER_LED) - cfg.rst_bits) :
                   (bit_in - cfg.rst_bits);
      colour     = (led < STORE_LIMIT) ? store_in[led[SIDX_W-1:0]] : '0;
      cur_bit    = colour[rlcs_pkg::BIT_LAST - data_bit];
      high_ticks = cur_bit ? cfg.one_high_ticks : cfg.zero_high_ticks;
      level_in   = sending_in && !in_lead && (led < LED_LIMIT) && (tick_in < high_ticks);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sending_ff <= 1'b0;
         word_ff    <= '0;
         bit_ff     <= '0;
         tick_ff    <= 8'd0;
         for (int i = 0; i < STORE_DEPTH; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         sending_ff <= sending_in;
         word_ff    <= word_in;
         bit_ff     <= bit_in;
         tick_ff    <= tick_in;
         store_ff   <= store_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (op_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (op_pop) begin
         level_ff <= level_in;
         busy_ff  <= sending_in;
         done_ff  <= done_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_line_level = level_ff;
   assign rsp_busy_res   = busy_ff;
   assign rsp_frame_done = done_ff;

endmodule

// ===== design/rgb_led_chain_serializer_top.sv =====
// Serializer for a chain of addressable rgb leds, one data line, grb order.
// req channel: cmd 0 writes red/green/blue for led pixel_index (indexes at or
// beyond LED_TOTAL are dropped), cmd 1 starts a frame unless one runs, cmd 2
// is one timing tick, cmd 3 does nothing. Every request gives one rsp
// transfer: the line level after it, busy and a one-shot frame_done flag.
// A frame is reset_slot_count low slots, then 24 bits per led, msb first,
// each slot bit_period_ticks ticks long, high for the one or zero time.
// csr channel: index 0..3 writes one-high, zero-high, period, reset slots;
// always ready, write only while no request is outstanding.
// Path: a request is first registered in the queue and then, once the
// output register is free or draining, in the rsp output register.
// Throughput: one request per cycle while rsp is not stalled; a two-entry
// queue sits between the decode front end and the frame engine, and the
// engine does one slot update and one store read per request.
// Reset (synchronous): colours go black, no frame runs, csrs take defaults.
// A stalled rsp holds its data; the queue takes up to two more requests
// and then drops req_ready until rsp transfers resume.
module rgb_led_chain_serializer_top #(
   parameter int LED_TOTAL = 24
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_cmd,
   input  logic [4:0] req_pixel_index,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_line_level,
   output logic       rsp_busy_res,
   output logic       rsp_frame_done,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   rlcs_pkg::cfg_type cfg_ff, cfg_in;
   rlcs_pkg::op_type  op;
   logic              op_valid;
   logic              op_pop;

   // csr registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            rlcs_pkg::CSR_ONE_HIGH:  cfg_in.one_high_ticks   = csr_wdata;
            rlcs_pkg::CSR_ZERO_HIGH: cfg_in.zero_high_ticks  = csr_wdata;
            rlcs_pkg::CSR_PERIOD:    cfg_in.bit_period_ticks = csr_wdata;
            rlcs_pkg::CSR_RST_SLOTS: begin
               // lead-in kept split into led words and leftover bits
               cfg_in.rst_words = rlcs_pkg::slot_words(csr_wdata);
               cfg_in.rst_bits  = rlcs_pkg::slot_bits(csr_wdata);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.one_high_ticks   <= rlcs_pkg::ONE_HIGH_RST;
         cfg_ff.zero_high_ticks  <= rlcs_pkg::ZERO_HIGH_RST;
         cfg_ff.bit_period_ticks <= rlcs_pkg::PERIOD_RST;
         cfg_ff.rst_words        <= rlcs_pkg::slot_words(rlcs_pkg::RST_SLOTS_RST);
         cfg_ff.rst_bits         <= rlcs_pkg::slot_bits(rlcs_pkg::RST_SLOTS_RST);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // decode and queue
   rlcs_front #(
      .LED_TOTAL(LED_TOTAL)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_pixel_index (req_pixel_index),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .op_valid        (op_valid),
      .op              (op),
      .op_pop          (op_pop)
   );

   // frame engine and colour store
   rlcs_back #(
      .LED_TOTAL(LED_TOTAL)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .op_valid       (op_valid),
      .op             (op),
      .op_pop         (op_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_line_level (rsp_line_level),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_frame_done (rsp_frame_done)
   );

endmodule

// ===== design/rlcs_checker.sv =====
module rlcs_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_line_level,
   input logic       rsp_busy_res,
   input logic       rsp_frame_done
);

   // reset leaves no result pending
   a_rst_clear: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

   // input backs up only behind a pending result
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_ready) |-> rsp_valid)
      else $error("req_ready low with no result pending");

   // a finished frame is no longer busy
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_done) |-> !rsp_busy_res)
      else $error("frame_done while busy");

   // the line is low whenever no frame runs
   a_idle_low: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_busy_res) |-> !rsp_line_level)
      else $error("line high while idle");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_line_level)
         && $stable(rsp_busy_res) && $stable(rsp_frame_done)))
      else $error("stalled rsp changed");

endmodule

bind rgb_led_chain_serializer_top rlcs_checker u_rlcs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_line_level (rsp_line_level),
   .rsp_busy_res   (rsp_busy_res),
   .rsp_frame_done (rsp_frame_done)
);

// ===== dv/rgb_led_chain_serializer_top_tb.sv =====
module rgb_led_chain_serializer_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CHAIN_LEDS = 24;
   localparam int STALL_LIMIT = 2500;
   localparam int HOLD_AFTER = 300;
   localparam int HOLD_CYCLES = 400;
   localparam int REPORT_MAX = 10;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      logic [1:0] cmd;
      logic [4:0] idx;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } led_request_type;

   typedef struct packed {
      logic level;
      logic busy;
      logic done;
   } line_state_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_cmd = rlcs_pkg::CMD_TICK;
   logic [4:0] req_pixel_index = '0;
   logic [7:0] req_red = '0;
   logic [7:0] req_green = '0;
   logic [7:0] req_blue = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_line_level;
   logic       rsp_busy_res;
   logic       rsp_frame_done;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = rlcs_pkg::CSR_ONE_HIGH;
   logic [7:0] csr_wdata = '0;

   // handshake flags seen at the last rising edge
   logic req_took = 1'b0;
   logic csr_took = 1'b0;

   led_request_type pending_requests[$];
   line_state_type  due_line_states[$];
   int requests_queued = 0;
   int requests_accepted = 0;
   int results_seen = 0;
   int mismatches = 0;
   int quiet_cycles = 0;

   // driver and receiver pacing
   int req_gap = 0;
   int req_calm = 0;
   int rsp_gap = 0;
   int rsp_calm = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   // chain model: colours, frame position and timing registers
   logic [23:0] colours[CHAIN_LEDS];
   bit          frame_on;
   int          slot_pos;
   int          tick_pos;
   logic [7:0]  one_ticks;
   logic [7:0]  zero_ticks;
   logic [7:0]  period_ticks;
   logic [7:0]  lead_slots;

   rgb_led_chain_serializer_top #(
      .LED_TOTAL(CHAIN_LEDS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_pixel_index(req_pixel_index),
      .req_red(req_red),
      .req_green(req_green),
      .req_blue(req_blue),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_line_level(rsp_line_level),
      .rsp_busy_res(rsp_busy_res),
      .rsp_frame_done(rsp_frame_done),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // gap length: mostly none, some short, a few long, with calm stretches
   function automatic int pick_gap(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(99);
      if (roll < 4) begin
         calm = $urandom_range(80, 20);
         return 0;
      end
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(3, 1);
      if (roll < 98) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic void clear_chain_model();
      foreach (colours[i]) colours[i] = '0;
      frame_on = 1'b0;
      slot_pos = 0;
      tick_pos = 0;
      one_ticks = rlcs_pkg::ONE_HIGH_RST;
      zero_ticks = rlcs_pkg::ZERO_HIGH_RST;
      period_ticks = rlcs_pkg::PERIOD_RST;
      lead_slots = rlcs_pkg::RST_SLOTS_RST;
   endfunction

   function automatic void apply_timing_reg(logic [1:0] index, logic [7:0] value);
      case (index)
         rlcs_pkg::CSR_ONE_HIGH:  one_ticks = value;
         rlcs_pkg::CSR_ZERO_HIGH: zero_ticks = value;
         rlcs_pkg::CSR_PERIOD:    period_ticks = value;
         rlcs_pkg::CSR_RST_SLOTS: lead_slots = value;
         default: ;
      endcase
   endfunction

   // advance the chain by one request and return the line it shows after
   function automatic line_state_type next_line_state(led_request_type rq);
      line_state_type res;
      int data_slot;
      int led;
      int bit_no;
      logic [7:0] high;
      res = '0;
      case (rq.cmd)
         rlcs_pkg::CMD_WRITE: begin
            if (rq.idx < CHAIN_LEDS) colours[rq.idx] = {rq.green, rq.red, rq.blue};
         end
         rlcs_pkg::CMD_START: begin
            if (!frame_on) begin
               frame_on = 1'b1;
               slot_pos = 0;
               tick_pos = 0;
            end
         end
         rlcs_pkg::CMD_TICK: begin
            if (frame_on) begin
               tick_pos++;
               if (tick_pos >= period_ticks) begin
                  tick_pos = 0;
                  slot_pos++;
                  if (slot_pos >= lead_slots + CHAIN_LEDS * rlcs_pkg::BITS_PER_LED) begin
                     frame_on = 1'b0;
                     slot_pos = 0;
                     res.done = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
      // level: low when idle or in a lead-in slot, else pulse by the bit
      if (frame_on && slot_pos >= lead_slots) begin
         data_slot = slot_pos - lead_slots;
         led = data_slot / rlcs_pkg::BITS_PER_LED;
         bit_no = data_slot % rlcs_pkg::BITS_PER_LED;
         if (led < CHAIN_LEDS) begin
            high = colours[led][23 - bit_no] ? one_ticks : zero_ticks;
            res.level = (tick_pos < high);
         end
      end
      res.busy = frame_on;
      return res;
   endfunction

   // request driver
   always @(negedge clock) begin : drive_req
      led_request_type rq;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            rq = pending_requests.pop_front();
            req_cmd <= rq.cmd;
            req_pixel_index <= rq.idx;
            req_red <= rq.red;
            req_green <= rq.green;
            req_blue <= rq.blue;
            req_valid <= 1'b1;
            req_gap = pick_gap(req_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response receiver, with one long hold-off to back up the input
   always @(negedge clock) begin : drive_rsp
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         rsp_gap = pick_gap(rsp_calm);
      end
   end

   // monitor: predict on request transfer, check on response transfer
   always @(posedge clock) begin : watch
      led_request_type rq;
      line_state_type want;
      line_state_type seen;
      if (reset) begin
         req_took <= 1'b0;
         csr_took <= 1'b0;
      end else begin
         req_took <= req_valid && req_ready;
         csr_took <= csr_valid && csr_ready;
         if (req_valid && req_ready) begin
            rq.cmd = req_cmd;
            rq.idx = req_pixel_index;
            rq.red = req_red;
            rq.green = req_green;
            rq.blue = req_blue;
            due_line_states.push_back(next_line_state(rq));
            requests_accepted++;
         end
         if (csr_valid && csr_ready) apply_timing_reg(csr_index, csr_wdata);
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_line_level, rsp_busy_res, rsp_frame_done};
            if (due_line_states.size() == 0) begin
               if (mismatches < REPORT_MAX)
                  $display("result %0d with nothing pending: level %0b busy %0b done %0b",
                           results_seen, seen.level, seen.busy, seen.done);
               mismatches++;
            end else begin
               want = due_line_states.pop_front();
               if (seen.level !== want.level || seen.busy !== want.busy ||
                   seen.done !== want.done) begin
                  if (mismatches < REPORT_MAX)
                     $display("result %0d: expected level %0b busy %0b done %0b, got %0b %0b %0b",
                              results_seen, want.level, want.busy, want.done,
                              seen.level, seen.busy, seen.done);
                  mismatches++;
               end
            end
            results_seen++;
         end
         // watchdog on cycles without any transfer
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   task automatic add_request(logic [1:0] cmd, logic [4:0] idx,
                              logic [7:0] red, logic [7:0] green, logic [7:0] blue);
      led_request_type rq;
      rq.cmd = cmd;
      rq.idx = idx;
      rq.red = red;
      rq.green = green;
      rq.blue = blue;
      pending_requests.push_back(rq);
      requests_queued++;
   endtask

   function automatic logic [7:0] pick_colour();
      int roll;
      roll = $urandom_range(9);
      if (roll == 0) return 8'h00;
      if (roll == 1) return 8'hff;
      return 8'($urandom_range(255));
   endfunction

   // a start, then mostly ticks with writes, restarts and noise mixed in
   task automatic add_random_requests(int count, int tick_pct);
      int roll;
      logic [1:0] cmd;
      logic [4:0] idx;
      add_request(rlcs_pkg::CMD_START, 5'($urandom_range(31)), pick_colour(), pick_colour(),
                  pick_colour());
      for (int n = 1; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < tick_pct) cmd = rlcs_pkg::CMD_TICK;
         else if (roll < tick_pct + (100 - tick_pct) * 65 / 100) cmd = rlcs_pkg::CMD_WRITE;
         else if (roll < tick_pct + (100 - tick_pct) * 90 / 100) cmd = rlcs_pkg::CMD_START;
         else cmd = CMD_UNUSED;
         if ($urandom_range(9) == 0) idx = 5'($urandom_range(31, CHAIN_LEDS));
         else idx = 5'($urandom_range(CHAIN_LEDS - 1));
         add_request(cmd, idx, pick_colour(), pick_colour(), pick_colour());
      end
   endtask

   // every queued request answered and nothing left to check
   task automatic wait_drained();
      while (requests_accepted != requests_queued || due_line_states.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_timing_reg(logic [1:0] index, logic [7:0] value);
      @(negedge clock);
      csr_index <= index;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(negedge clock); while (!csr_took);
      csr_valid <= 1'b0;
   endtask

   task automatic program_timing(logic [7:0] one_hi, logic [7:0] zero_hi,
                                 logic [7:0] period, logic [7:0] lead);
      wait_drained();
      write_timing_reg(rlcs_pkg::CSR_ONE_HIGH, one_hi);
      write_timing_reg(rlcs_pkg::CSR_ZERO_HIGH, zero_hi);
      write_timing_reg(rlcs_pkg::CSR_PERIOD, period);
      write_timing_reg(rlcs_pkg::CSR_RST_SLOTS, lead);
   endtask

   initial begin
      clear_chain_model();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: idle tick, unused code, edge indexes and colours, restart
      add_request(rlcs_pkg::CMD_TICK, 5'd0, 8'h00, 8'h00, 8'h00);
      add_request(CMD_UNUSED, 5'd31, 8'hff, 8'hff, 8'hff);
      add_request(rlcs_pkg::CMD_WRITE, 5'd0, 8'hff, 8'hff, 8'hff);
      add_request(rlcs_pkg::CMD_WRITE, 5'd23, 8'h01, 8'h80, 8'h7f);
      add_request(rlcs_pkg::CMD_WRITE, 5'd24, 8'hff, 8'hff, 8'hff);
      add_request(rlcs_pkg::CMD_WRITE, 5'd31, 8'h00, 8'h00, 8'h00);
      add_request(rlcs_pkg::CMD_WRITE, 5'd5, 8'haa, 8'h55, 8'h0f);
      add_request(rlcs_pkg::CMD_START, 5'd0, 8'h00, 8'h00, 8'h00);
      add_request(rlcs_pkg::CMD_START, 5'd31, 8'hff, 8'hff, 8'hff);
      add_request(rlcs_pkg::CMD_TICK, 5'd31, 8'hff, 8'hff, 8'hff);
      add_request(rlcs_pkg::CMD_TICK, 5'd0, 8'h00, 8'h00, 8'h00);
      add_request(rlcs_pkg::CMD_WRITE, 5'd1, 8'h5a, 8'ha5, 8'hc3);
      add_request(CMD_UNUSED, 5'd0, 8'h00, 8'h00, 8'h00);
      add_request(rlcs_pkg::CMD_TICK, 5'd7, 8'h12, 8'h34, 8'h56);
      add_request(rlcs_pkg::CMD_START, 5'd3, 8'h00, 8'h00, 8'h00);
      add_request(rlcs_pkg::CMD_TICK, 5'd0, 8'h00, 8'h00, 8'h00);

      // one-tick slots, no lead-in: long enough to finish a frame
      program_timing(8'd0, 8'd255, 8'd1, 8'd0);
      add_random_requests(620, 96);

      // zero period, longest lead-in, high times swapped
      program_timing(8'd255, 8'd0, 8'd0, 8'd255);
      add_random_requests(120, 90);

      program_timing(8'd2, 8'd1, 8'd3, 8'd2);
      add_random_requests(200, 92);

      // random timing
      program_timing(8'($urandom_range(5)), 8'($urandom_range(5)),
                     8'($urandom_range(4, 2)), 8'($urandom_range(6)));
      add_random_requests(150, 88);

      // longest period
      program_timing(8'd255, 8'd128, 8'd255, 8'd1);
      add_random_requests(50, 80);

      program_timing(8'($urandom_range(2)), 8'($urandom_range(2)), 8'd1,
                     8'($urandom_range(3)));
      add_random_requests(320, 95);

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && due_line_states.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== rgb_led_chain_serializer_top.f =====
design/rlcs_pkg.sv
design/rlcs_front.sv
design/rlcs_back.sv
design/rgb_led_chain_serializer_top.sv
design/rlcs_checker.sv
dv/rgb_led_chain_serializer_top_tb.sv
